>>> hw/rtl/two_channel_peak_to_peak_gain_macros.svh
// Assertion shorthands used by p2pg_divider. Every check is sampled on the
// rising edge of clk_i and is switched off while rst_ni is low.
`ifndef TWO_CHANNEL_PEAK_TO_PEAK_GAIN_MACROS_SVH
`define TWO_CHANNEL_PEAK_TO_PEAK_GAIN_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define P2PG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge out of reset.
`define P2PG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/p2pg_pkg.sv
`default_nettype none

package p2pg_pkg;

  // Converter code width and the number of fraction bits of the gain.
  localparam int SAMPLE_BITS    = 12;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int GAIN_BITS      = 16;

  // The dividend is the output swing followed by the fraction bits.
  localparam int NUM_BITS = SAMPLE_BITS + GAIN_FRAC_BITS;

  localparam int CNT_BITS  = $clog2(SAMPLE_BITS);
  localparam int STEP_BITS = $clog2(NUM_BITS);

  localparam logic [GAIN_BITS-1:0] GAIN_MAX = {GAIN_BITS{1'b1}};

  // Commands from the sequencer to both channel trackers.
  typedef struct packed {
    logic load;    // capture a new sample
    logic cmp;     // one bit of the serial compare against low and high
    logic commit;  // take the sample as new low and/or high
    logic sub;     // one bit of the serial swing subtraction
    logic clear;   // return low and high to their block start values
  } tr_ctrl_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] vout_swing;
    logic [SAMPLE_BITS-1:0] vin_swing;
    logic [GAIN_BITS-1:0]   gain_ratio;
    logic                   gain_valid;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/p2pg_if.sv
`default_nettype none

// Sample pair channel.
interface p2pg_in_if import p2pg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] out_sample;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   block_end;

  modport source (output valid, output out_sample, output in_sample, output block_end,
                  input ready);
  modport sink   (input valid, input out_sample, input in_sample, input block_end,
                  output ready);
endinterface

// Result channel.
interface p2pg_out_if import p2pg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] vout_swing;
  logic [SAMPLE_BITS-1:0] vin_swing;
  logic [GAIN_BITS-1:0]   gain_ratio;
  logic                   gain_valid;

  modport source (output valid, output vout_swing, output vin_swing, output gain_ratio,
                  output gain_valid, input ready);
  modport sink   (input valid, input vout_swing, input vin_swing, input gain_ratio,
                  input gain_valid, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/two_channel_peak_to_peak_gain.sv
`default_nettype none

// Two-channel peak-to-peak gain meter. Each accepted word is a pair of
// converter codes, the filter output and the filter input, plus a flag that
// marks the last pair of a measurement block. Both channels keep a running
// minimum and maximum; on the flagged pair (which is counted first) the block
// sends one result word with both swings in raw codes, the gain as output
// swing over input swing in unsigned Q4.12 (truncated, saturating at all
// ones), and a flag that is low, with a zero gain, when the input swing is
// zero. The trackers then start over. Pairs without the flag produce nothing.
// The trackers compare one bit per cycle, so a pair occupies the input from
// acceptance through the serial compare and the commit until the next ready.
// A flagged pair then subtracts the swings serially and hands them to the
// divider. The divider produces one quotient bit per cycle and holds its
// result word until the sink takes it; meanwhile the next block is tracked.
// A flagged pair stalls in the hand-over only if the divider is still busy or
// its result word has not been taken.
module two_channel_peak_to_peak_gain import p2pg_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  p2pg_in_if.sink     in_i,
  p2pg_out_if.source  out_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CMP    = 5'b00010,
    ST_COMMIT = 5'b00100,
    ST_SUB    = 5'b01000,
    ST_HAND   = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic                   last_q, last_d;
  logic                   cnt_end;
  logic                   in_fire;
  tr_ctrl_t               tr_ctrl;
  logic [SAMPLE_BITS-1:0] vout_swing;
  logic [SAMPLE_BITS-1:0] vin_swing;
  logic                   div_start;
  logic                   div_ready;
  result_t                res;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign cnt_end    = (cnt_q == CNT_BITS'(SAMPLE_BITS - 1));

  // Sequencer: accept, serial compare, commit, and for the block end a serial
  // subtraction and the hand-over to the divider.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    tr_ctrl   = '0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          tr_ctrl.load = 1'b1;
          last_d       = in_i.block_end;
          cnt_d        = '0;
          state_d      = ST_CMP;
        end
      end
      ST_CMP: begin
        tr_ctrl.cmp = 1'b1;
        if (cnt_end) begin
          state_d = ST_COMMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_COMMIT: begin
        tr_ctrl.commit = 1'b1;
        cnt_d          = '0;
        state_d        = last_q ? ST_SUB : ST_IDLE;
      end
      ST_SUB: begin
        tr_ctrl.sub = 1'b1;
        if (cnt_end) begin
          state_d = ST_HAND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_HAND: begin
        // The trackers are cleared in the same cycle the divider takes the
        // swings, so the next block starts from a clean state.
        div_start = 1'b1;
        if (div_ready) begin
          tr_ctrl.clear = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

  p2pg_tracker u_out_trk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (tr_ctrl),
    .sample_i (in_i.out_sample),
    .swing_o  (vout_swing)
  );

  p2pg_tracker u_in_trk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (tr_ctrl),
    .sample_i (in_i.in_sample),
    .swing_o  (vin_swing)
  );

  p2pg_divider u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (div_start),
    .vout_swing_i (vout_swing),
    .vin_swing_i  (vin_swing),
    .ready_o      (div_ready),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .res_o        (res)
  );

  assign out_o.vout_swing = res.vout_swing;
  assign out_o.vin_swing  = res.vin_swing;
  assign out_o.gain_ratio = res.gain_ratio;
  assign out_o.gain_valid = res.gain_valid;

endmodule

`default_nettype wire

>>> hw/rtl/p2pg_tracker.sv
`default_nettype none

// Minimum and maximum tracker of one channel. Compare and subtract run one bit
// per cycle, least significant bit first, while the words rotate in place.
module p2pg_tracker import p2pg_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tr_ctrl_t               ctrl_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic      [SAMPLE_BITS-1:0] swing_o
);

  logic [SAMPLE_BITS-1:0] smp_q, smp_d;
  logic [SAMPLE_BITS-1:0] low_q, low_d;
  logic [SAMPLE_BITS-1:0] high_q, high_d;
  logic [SAMPLE_BITS-1:0] swing_q, swing_d;
  logic                   lt_q, lt_d;
  logic                   gt_q, gt_d;
  logic                   borrow_q, borrow_d;
  logic                   s_bit, l_bit, h_bit;

  assign s_bit = smp_q[0];
  assign l_bit = low_q[0];
  assign h_bit = high_q[0];

  always_comb begin
    smp_d    = smp_q;
    low_d    = low_q;
    high_d   = high_q;
    swing_d  = swing_q;
    lt_d     = lt_q;
    gt_d     = gt_q;
    borrow_d = borrow_q;
    if (ctrl_i.load) begin
      smp_d = sample_i;
      lt_d  = 1'b0;
      gt_d  = 1'b0;
    end
    if (ctrl_i.cmp) begin
      // The highest differing bit is seen last, so it has the final say.
      if (s_bit != l_bit) begin
        lt_d = ~s_bit;
      end
      if (s_bit != h_bit) begin
        gt_d = s_bit;
      end
      smp_d  = {smp_q[0], smp_q[SAMPLE_BITS-1:1]};
      low_d  = {low_q[0], low_q[SAMPLE_BITS-1:1]};
      high_d = {high_q[0], high_q[SAMPLE_BITS-1:1]};
    end
    if (ctrl_i.commit) begin
      if (lt_q) begin
        low_d = smp_q;
      end
      if (gt_q) begin
        high_d = smp_q;
      end
      borrow_d = 1'b0;
    end
    if (ctrl_i.sub) begin
      swing_d  = {h_bit ^ l_bit ^ borrow_q, swing_q[SAMPLE_BITS-1:1]};
      borrow_d = (~h_bit & l_bit) | (~(h_bit ^ l_bit) & borrow_q);
      low_d    = {low_q[0], low_q[SAMPLE_BITS-1:1]};
      high_d   = {high_q[0], high_q[SAMPLE_BITS-1:1]};
    end
    if (ctrl_i.clear) begin
      low_d  = {SAMPLE_BITS{1'b1}};
      high_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= {SAMPLE_BITS{1'b1}};
      high_q <= '0;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q    <= smp_d;
    swing_q  <= swing_d;
    lt_q     <= lt_d;
    gt_q     <= gt_d;
    borrow_q <= borrow_d;
  end

  assign swing_o = swing_q;

endmodule

`default_nettype wire

>>> hw/rtl/p2pg_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. It also holds the finished
// result until the result channel takes it.
module p2pg_divider import p2pg_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [SAMPLE_BITS-1:0] vout_swing_i,
  input  wire logic [SAMPLE_BITS-1:0] vin_swing_i,
  output logic                        ready_o,
  output logic                        res_valid_o,
  input  wire logic                   res_ready_i,
  output result_t                     res_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [STEP_BITS-1:0]   step_q, step_d;
  logic [SAMPLE_BITS-1:0] so_q, so_d;
  logic [SAMPLE_BITS-1:0] si_q, si_d;
  logic [NUM_BITS-1:0]    num_q, num_d;
  logic [SAMPLE_BITS-1:0] rem_q, rem_d;
  logic [GAIN_BITS-1:0]   quo_q, quo_d;
  logic                   ovf_q, ovf_d;
  logic [SAMPLE_BITS:0]   trial;
  logic [SAMPLE_BITS+1:0] diff;
  logic                   fits;

  assign ready_o = !busy_q && !done_q;

  assign trial = {rem_q, num_q[NUM_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, si_q};
  assign fits  = ~diff[SAMPLE_BITS+1];

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    so_d   = so_q;
    si_d   = si_q;
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    if (start_i && ready_o) begin
      busy_d = 1'b1;
      step_d = '0;
      so_d   = vout_swing_i;
      si_d   = vin_swing_i;
      num_d  = {vout_swing_i, {GAIN_FRAC_BITS{1'b0}}};
      rem_d  = '0;
      quo_d  = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      rem_d = fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
      num_d = {num_q[NUM_BITS-2:0], 1'b0};
      quo_d = {quo_q[GAIN_BITS-2:0], fits};
      // A one pushed out of the top means the quotient needs more bits.
      ovf_d = ovf_q | quo_q[GAIN_BITS-1];
      if (step_q == STEP_BITS'(NUM_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end else if (done_q && res_ready_i) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    so_q  <= so_d;
    si_q  <= si_d;
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  always_comb begin
    res_o.vout_swing = so_q;
    res_o.vin_swing  = si_q;
    res_o.gain_valid = (si_q != '0);
    if (si_q == '0) begin
      res_o.gain_ratio = '0;
    end else if (ovf_q) begin
      res_o.gain_ratio = GAIN_MAX;
    end else begin
      res_o.gain_ratio = quo_q;
    end
  end

  assign res_valid_o = done_q;

`include "two_channel_peak_to_peak_gain_macros.svh"

  `P2PG_ASSERT_NEVER(a_busy_and_done, busy_q && done_q, "divider busy while holding a result")
  `P2PG_ASSERT(a_start_runs, start_i && ready_o |=> busy_q, "accepted division did not start")
  `P2PG_ASSERT(a_rem_below_div, done_q && (si_q != '0) |-> rem_q < si_q,
               "final remainder not below the divisor")

endmodule

`default_nettype wire
